// ===== design/depth_and_thruster_command_controller_defines.svh =====
// Assertion macros used by the checker file of the depth and thruster controller.
// Every macro samples on clk and stays off while rst_n is low.
`ifndef DEPTH_AND_THRUSTER_COMMAND_CONTROLLER_DEFINES_SVH
`define DEPTH_AND_THRUSTER_COMMAND_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dtcc_pkg;

  localparam int PRESS_W = 16;
  localparam int CHAR_W = 8;
  localparam int DRIVE_W = 11;
  localparam int SETPT_W = 9;
  localparam int GAIN_W = 4;
  localparam int FEET_W = 5;

  // Depth arithmetic: depth = trunc((p * 1370 - 11878400) / 65536).
  localparam int DEPTH_MUL = 1370;
  localparam int DEPTH_OFFSET = 11878400;
  localparam int DEPTH_SHIFT = 16;
  localparam int PROD_W = 28;
  localparam int DIFF_W = PROD_W + 1;
  localparam int DEPTH_W = DIFF_W - DEPTH_SHIFT;
  localparam int ERR_W = DEPTH_W + 2;
  localparam int OUT_W = ERR_W + GAIN_W + 1;

  localparam int QUARTERS_PER_FOOT = 25;
  localparam int DRIVE_STEP = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] ASCII_0 = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_9 = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_D = 8'h64;
  localparam logic [CHAR_W-1:0] ASCII_E = 8'h65;
  localparam logic [CHAR_W-1:0] ASCII_G = 8'h67;
  localparam logic [CHAR_W-1:0] ASCII_O = 8'h6f;
  localparam logic [CHAR_W-1:0] ASCII_Q = 8'h71;
  localparam logic [CHAR_W-1:0] ASCII_R = 8'h72;
  localparam logic [CHAR_W-1:0] ASCII_S = 8'h73;
  localparam logic [CHAR_W-1:0] ASCII_T = 8'h74;
  localparam logic [CHAR_W-1:0] ASCII_U = 8'h75;
  localparam logic [CHAR_W-1:0] ASCII_W = 8'h77;
  localparam logic [CHAR_W-1:0] ASCII_X = 8'h78;
  localparam logic [CHAR_W-1:0] ASCII_Y = 8'h79;

  typedef enum logic [1:0] {
    STATUS_WAIT    = 2'd0,
    STATUS_ACCEPT  = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    KIND_NUL   = 4'd0,
    KIND_W     = 4'd1,
    KIND_S     = 4'd2,
    KIND_A     = 4'd3,
    KIND_D     = 4'd4,
    KIND_X     = 4'd5,
    KIND_O     = 4'd6,
    KIND_G     = 4'd7,
    KIND_OTHER = 4'd8
  } char_kind_t;

  typedef struct packed {
    logic                      is_tick;
    char_kind_t                kind;
    logic                      feet_valid;
    logic [SETPT_W-1:0]        setpt;
    logic                      digit_valid;
    logic [GAIN_W-1:0]         gain;
    logic signed [PRESS_W-1:0] pressure;
  } dtcc_item_t;

endpackage
`default_nettype wire

// ===== design/depth_and_thruster_command_controller.sv =====
// Path: input register, two-entry queue, executor; a sample that runs the controller
// also runs the multiplier chain: scale multiply, error, gain multiply, saturate.
// Throughput: one beat per cycle for characters while the output is free and the
// executor is idle; a controller sample holds the executor through its whole chain.
// Reset: synchronous active-low rst_n clears the queue, handshakes and the controller's
// mode, setpoint, gain and drive state; the block takes input in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module depth_and_thruster_command_controller #(
  parameter int DRIVE_LIMIT = 100
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_req_type,
  input  wire logic [dtcc_pkg::CHAR_W-1:0]         in_char_code,
  input  wire logic signed [dtcc_pkg::PRESS_W-1:0] in_pressure_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               out_status,
  output logic signed [dtcc_pkg::DRIVE_W-1:0]      out_vertical_drive,
  output logic signed [dtcc_pkg::DRIVE_W-1:0]      out_left_drive,
  output logic signed [dtcc_pkg::DRIVE_W-1:0]      out_right_drive,
  output logic                                     out_running,
  output logic                                     out_depth_enabled
);
  import dtcc_pkg::*;

  logic       fr_valid;
  logic       fr_ready;
  dtcc_item_t fr_item;
  logic       q_valid;
  logic       q_pop;
  dtcc_item_t q_item;

  dtcc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_char_code       (in_char_code),
    .in_pressure_sample (in_pressure_sample),
    .item_valid         (fr_valid),
    .item_ready         (fr_ready),
    .item               (fr_item)
  );

  dtcc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_item   (q_item)
  );

  dtcc_back #(
    .DRIVE_LIMIT (DRIVE_LIMIT)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_item             (q_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_vertical_drive (out_vertical_drive),
    .out_left_drive     (out_left_drive),
    .out_right_drive    (out_right_drive),
    .out_running        (out_running),
    .out_depth_enabled  (out_depth_enabled)
  );

endmodule
`default_nettype wire

// ===== design/dtcc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtcc_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_req_type,
  input  wire logic [dtcc_pkg::CHAR_W-1:0]        in_char_code,
  input  wire logic signed [dtcc_pkg::PRESS_W-1:0] in_pressure_sample,
  output logic                                    item_valid,
  input  wire logic                               item_ready,
  output dtcc_pkg::dtcc_item_t                    item
);
  import dtcc_pkg::*;

  logic       vld_r;
  logic       vld_nxt;
  dtcc_item_t item_r;
  dtcc_item_t item_nxt;
  logic [FEET_W-1:0] feet;

  assign in_ready   = !vld_r || item_ready;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.is_tick  = in_req_type;
    item_nxt.pressure = in_pressure_sample;
    case (in_char_code)
      ASCII_NUL: item_nxt.kind = KIND_NUL;
      ASCII_W:   item_nxt.kind = KIND_W;
      ASCII_S:   item_nxt.kind = KIND_S;
      ASCII_A:   item_nxt.kind = KIND_A;
      ASCII_D:   item_nxt.kind = KIND_D;
      ASCII_X:   item_nxt.kind = KIND_X;
      ASCII_O:   item_nxt.kind = KIND_O;
      ASCII_G:   item_nxt.kind = KIND_G;
      default:   item_nxt.kind = KIND_OTHER;
    endcase

    item_nxt.digit_valid = (in_char_code >= ASCII_0) && (in_char_code <= ASCII_9);
    item_nxt.gain = GAIN_W'(in_char_code - ASCII_0) + GAIN_W'(1);

    // Setpoint letters continue the digits from ten feet upward.
    item_nxt.feet_valid = 1'b1;
    case (in_char_code)
      ASCII_Q: feet = FEET_W'(10);
      ASCII_W: feet = FEET_W'(11);
      ASCII_E: feet = FEET_W'(12);
      ASCII_R: feet = FEET_W'(13);
      ASCII_T: feet = FEET_W'(14);
      ASCII_Y: feet = FEET_W'(15);
      ASCII_U: feet = FEET_W'(16);
      default: begin
        feet = FEET_W'(in_char_code - ASCII_0);
        item_nxt.feet_valid = item_nxt.digit_valid;
      end
    endcase
    item_nxt.setpt = SETPT_W'(feet * QUARTERS_PER_FOOT);

    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (item_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/dtcc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtcc_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire dtcc_pkg::dtcc_item_t push_item,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output dtcc_pkg::dtcc_item_t      pop_item
);
  import dtcc_pkg::*;

  dtcc_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/dtcc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtcc_back #(
  parameter int DRIVE_LIMIT = 100
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  output logic                                     q_pop,
  input  wire dtcc_pkg::dtcc_item_t                q_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               out_status,
  output logic signed [dtcc_pkg::DRIVE_W-1:0]      out_vertical_drive,
  output logic signed [dtcc_pkg::DRIVE_W-1:0]      out_left_drive,
  output logic signed [dtcc_pkg::DRIVE_W-1:0]      out_right_drive,
  output logic                                     out_running,
  output logic                                     out_depth_enabled
);
  import dtcc_pkg::*;

  typedef enum logic [3:0] {
    BK_IDLE  = 4'b0001,
    BK_DEPTH = 4'b0010,
    BK_GAIN  = 4'b0100,
    BK_SAT   = 4'b1000
  } bk_state_t;

  typedef enum logic [1:0] {
    MENU_FIRST = 2'd0,
    MENU_DEPTH = 2'd1,
    MENU_GAIN  = 2'd2
  } menu_stage_t;

  localparam logic signed [DRIVE_W-1:0] LIMIT_POS = DRIVE_W'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] LIMIT_NEG = DRIVE_W'(-DRIVE_LIMIT);
  localparam logic signed [DRIVE_W-1:0] STEP = DRIVE_W'(DRIVE_STEP);
  localparam logic signed [OUT_W-1:0]   QLIM_POS = OUT_W'(4 * DRIVE_LIMIT);
  localparam logic signed [OUT_W-1:0]   QLIM_NEG = OUT_W'(-4 * DRIVE_LIMIT);
  localparam logic signed [PROD_W-1:0]  MUL_K = PROD_W'(DEPTH_MUL);
  localparam logic signed [DIFF_W-1:0]  OFFSET_K = DIFF_W'(DEPTH_OFFSET);
  localparam logic signed [DIFF_W-1:0]  ROUND_K = DIFF_W'((1 << DEPTH_SHIFT) - 1);

  bk_state_t   state_r, state_nxt;
  menu_stage_t stage_r, stage_nxt;
  logic        run_r, run_nxt;
  logic        depth_on_r, depth_on_nxt;
  logic [SETPT_W-1:0] setpt_r, setpt_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic signed [DRIVE_W-1:0] left_r, left_nxt;
  logic signed [DRIVE_W-1:0] right_r, right_nxt;
  logic signed [DRIVE_W-1:0] vert_r, vert_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [OUT_W-1:0]   gout_r, gout_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r;
  logic signed [DRIVE_W-1:0] out_vert_r, out_left_r, out_right_r;
  logic        out_run_r, out_depth_r;

  logic        out_free;
  logic        load_out;
  status_t     status;
  logic signed [DRIVE_W-1:0] r0, l0;
  logic signed [PROD_W-1:0]  press_ext;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  biased;
  logic signed [DEPTH_W-1:0] depth;
  logic signed [OUT_W-1:0]   gain_ext;
  logic signed [OUT_W-1:0]   err_ext;
  logic signed [OUT_W-1:0]   gout_adj;

  assign out_free = !out_valid_r || out_ready;

  assign press_ext = {{(PROD_W-PRESS_W){q_item.pressure[PRESS_W-1]}}, q_item.pressure};
  assign diff      = {prod_r[PROD_W-1], prod_r} - OFFSET_K;
  assign biased    = diff[DIFF_W-1] ? diff + ROUND_K : diff;
  assign depth     = biased[DIFF_W-1:DEPTH_SHIFT];
  assign gain_ext  = {{(OUT_W-GAIN_W){1'b0}}, gain_r};
  assign err_ext   = {{(OUT_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign gout_adj  = gout_r[OUT_W-1] ? gout_r + OUT_W'(3) : gout_r;

  always_comb begin
    state_nxt    = state_r;
    stage_nxt    = stage_r;
    run_nxt      = run_r;
    depth_on_nxt = depth_on_r;
    setpt_nxt    = setpt_r;
    gain_nxt     = gain_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    vert_nxt     = vert_r;
    prod_nxt     = prod_r;
    err_nxt      = err_r;
    gout_nxt     = gout_r;
    status       = STATUS_IGNORED;
    load_out     = 1'b0;
    q_pop        = 1'b0;
    r0           = right_r;
    l0           = left_r;

    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.is_tick) begin
            if (run_r && depth_on_r) begin
              prod_nxt  = press_ext * MUL_K;
              state_nxt = BK_DEPTH;
            end else begin
              load_out = 1'b1;
            end
          end else begin
            load_out = 1'b1;
            if (q_item.kind == KIND_NUL) begin
              status = STATUS_IGNORED;
            end else if (!run_r) begin
              if (q_item.kind == KIND_S) begin
                run_nxt   = 1'b1;
                stage_nxt = MENU_FIRST;
                status    = STATUS_ACCEPT;
              end
            end else begin
              stage_nxt = MENU_FIRST;
              case (stage_r)
                MENU_DEPTH: begin
                  if (q_item.feet_valid) begin
                    setpt_nxt    = q_item.setpt;
                    depth_on_nxt = 1'b1;
                    status       = STATUS_ACCEPT;
                  end else if (q_item.kind == KIND_X) begin
                    depth_on_nxt = 1'b0;
                    vert_nxt     = '0;
                    status       = STATUS_ACCEPT;
                  end else if (q_item.kind == KIND_G) begin
                    stage_nxt = MENU_GAIN;
                    status    = STATUS_WAIT;
                  end else begin
                    status = STATUS_INVALID;
                  end
                end
                MENU_GAIN: begin
                  if (q_item.digit_valid) begin
                    gain_nxt = q_item.gain;
                    status   = STATUS_ACCEPT;
                  end else begin
                    status = STATUS_INVALID;
                  end
                end
                default: begin
                  status = STATUS_ACCEPT;
                  case (q_item.kind)
                    KIND_W: begin
                      if (right_r != left_r) begin
                        r0 = '0;
                        l0 = '0;
                      end
                      right_nxt = r0;
                      left_nxt  = l0;
                      if (r0 < LIMIT_POS) begin
                        right_nxt = r0 + STEP;
                        left_nxt  = l0 + STEP;
                      end
                    end
                    KIND_S: begin
                      if (right_r != left_r) begin
                        r0 = '0;
                        l0 = '0;
                      end
                      right_nxt = r0;
                      left_nxt  = l0;
                      if (r0 > LIMIT_NEG) begin
                        right_nxt = r0 - STEP;
                        left_nxt  = l0 - STEP;
                      end
                    end
                    KIND_A: begin
                      if (right_r == left_r) begin
                        r0 = '0;
                        l0 = '0;
                      end
                      right_nxt = r0;
                      left_nxt  = l0;
                      if (r0 < LIMIT_POS) begin
                        right_nxt = r0 + STEP;
                        left_nxt  = l0 - STEP;
                      end
                    end
                    KIND_D: begin
                      if (right_r == left_r) begin
                        r0 = '0;
                        l0 = '0;
                      end
                      right_nxt = r0;
                      left_nxt  = l0;
                      if (l0 < LIMIT_POS) begin
                        right_nxt = r0 - STEP;
                        left_nxt  = l0 + STEP;
                      end
                    end
                    KIND_X: begin
                      run_nxt      = 1'b0;
                      depth_on_nxt = 1'b0;
                      vert_nxt     = '0;
                    end
                    KIND_O: begin
                      stage_nxt = MENU_DEPTH;
                      status    = STATUS_WAIT;
                    end
                    default: begin
                      status = STATUS_INVALID;
                    end
                  endcase
                end
              endcase
            end
          end
        end
      end
      BK_DEPTH: begin
        // Error in quarter units: setpoint minus four times the depth.
        err_nxt   = {{(ERR_W-SETPT_W){1'b0}}, setpt_r} - {depth, 2'b00};
        state_nxt = BK_GAIN;
      end
      BK_GAIN: begin
        gout_nxt  = gain_ext * err_ext;
        state_nxt = BK_SAT;
      end
      BK_SAT: begin
        if (gout_r > QLIM_POS) begin
          vert_nxt = LIMIT_POS;
        end else if (gout_r < QLIM_NEG) begin
          vert_nxt = LIMIT_NEG;
        end else begin
          vert_nxt = gout_adj[DRIVE_W+1:2];
        end
        load_out  = 1'b1;
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      stage_r     <= MENU_FIRST;
      run_r       <= 1'b0;
      depth_on_r  <= 1'b0;
      setpt_r     <= '0;
      gain_r      <= '0;
      left_r      <= '0;
      right_r     <= '0;
      vert_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      run_r       <= run_nxt;
      depth_on_r  <= depth_on_nxt;
      setpt_r     <= setpt_nxt;
      gain_r      <= gain_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      vert_r      <= vert_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    err_r  <= err_nxt;
    gout_r <= gout_nxt;
    if (load_out) begin
      out_status_r <= status;
      out_vert_r   <= vert_nxt;
      out_left_r   <= run_nxt ? left_nxt : '0;
      out_right_r  <= run_nxt ? right_nxt : '0;
      out_run_r    <= run_nxt;
      out_depth_r  <= depth_on_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_vertical_drive = out_vert_r;
  assign out_left_drive     = out_left_r;
  assign out_right_drive    = out_right_r;
  assign out_running        = out_run_r;
  assign out_depth_enabled  = out_depth_r;

endmodule
`default_nettype wire

// ===== design/dtcc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "depth_and_thruster_command_controller_defines.svh"
module dtcc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [1:0]                          out_status,
  input wire logic signed [dtcc_pkg::DRIVE_W-1:0] out_vertical_drive,
  input wire logic signed [dtcc_pkg::DRIVE_W-1:0] out_left_drive,
  input wire logic signed [dtcc_pkg::DRIVE_W-1:0] out_right_drive,
  input wire logic                                out_running,
  input wire logic                                out_depth_enabled
);

  // A stalled result beat must keep its status and vertical drive.
  `DTCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_vertical_drive), "result beat changed while stalled")

  // A stopped block shows no horizontal drive.
  `DTCC_ASSERT_SAME(a_stopped_drive, out_valid && !out_running, out_left_drive == 0 && out_right_drive == 0, "horizontal drive while stopped")

  // Halting always switches the depth controller off.
  `DTCC_ASSERT_SAME(a_stopped_depth, out_valid && !out_running, !out_depth_enabled, "depth controller on while stopped")

  // Every path that disables the controller also zeroes the vertical drive.
  `DTCC_ASSERT_SAME(a_vert_idle, out_valid && !out_depth_enabled, out_vertical_drive == 0, "vertical drive without depth control")

endmodule

bind depth_and_thruster_command_controller dtcc_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_vertical_drive (out_vertical_drive),
  .out_left_drive     (out_left_drive),
  .out_right_drive    (out_right_drive),
  .out_running        (out_running),
  .out_depth_enabled  (out_depth_enabled)
);
`default_nettype wire
